// File: design/magnetometer_tilt_compensation_unit_defines.svh
// Assertion macros for the tilt compensation unit.
// Expects aclk and aresetn in the scope of use.
`ifndef MAGNETOMETER_TILT_COMPENSATION_UNIT_DEFINES_SVH
`define MAGNETOMETER_TILT_COMPENSATION_UNIT_DEFINES_SVH

// same-cycle implication
`define MTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mtc_pkg.sv
// Shared constants and types for the tilt compensation unit.
// No dependencies.
package mtc_pkg;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X    = 2'd0;
    localparam axis_t AXIS_Y    = 2'd1;
    localparam axis_t AXIS_Z    = 2'd2;
    localparam axis_t AXIS_NONE = 2'd3;

    localparam int RATIO_W    = 33;
    localparam int DIV_W      = RATIO_W + 1;
    localparam int QUO_W      = 31;
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_STEPS = 16;
    localparam int ROOT_W     = 32;
    localparam int RATIO_LAT  = DIV_STEPS + ROOT_STEPS;

    localparam int Q15_W = 15;
    localparam logic [Q15_W-1:0] Q15_MAX = 15'h7FFF;
    localparam int TRIG_W = Q15_W + 1;
    localparam int ROUND_HALF = 16384;
    localparam int FRAC_BITS  = 15;

    localparam int OUT_W   = 17;
    localparam int OUT_MAX = 65535;
    localparam int OUT_MIN = -65536;
    localparam int OUT_TW  = ((3 * OUT_W + 7) / 8) * 8;

endpackage

// File: design/mtc_ratio.sv
// Pipelined Q0.15 square-root ratio: floor(sqrt(num * 2^30 / den)), saturated.
// Restoring divider then restoring square root, one bit per stage. Uses mtc_pkg.
module mtc_ratio (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [mtc_pkg::RATIO_W-1:0]   num,
    input  logic [mtc_pkg::RATIO_W-1:0]   den,
    output logic [mtc_pkg::Q15_W-1:0]     root
);

    logic [mtc_pkg::DIV_W-1:0]   rem_reg [mtc_pkg::DIV_STEPS];
    logic [mtc_pkg::RATIO_W-1:0] den_reg [mtc_pkg::DIV_STEPS];
    logic [mtc_pkg::QUO_W-1:0]   quo_reg [mtc_pkg::DIV_STEPS];

    logic [mtc_pkg::ROOT_W-1:0]  rad_reg [mtc_pkg::ROOT_STEPS];
    logic [mtc_pkg::ROOT_W-1:0]  acc_reg [mtc_pkg::ROOT_STEPS];

    for (genvar k = 0; k < mtc_pkg::DIV_STEPS; k++) begin : g_div
        logic [mtc_pkg::DIV_W-1:0]   r_cur;
        logic [mtc_pkg::DIV_W-1:0]   r_next;
        logic [mtc_pkg::RATIO_W-1:0] d_cur;
        logic [mtc_pkg::QUO_W-1:0]   q_cur;
        logic                        q_bit;

        if (k == 0) begin : g_first
            assign r_cur = {1'b0, num};
            assign d_cur = den;
            assign q_cur = '0;
        end else begin : g_rest
            assign r_cur = {rem_reg[k-1][mtc_pkg::DIV_W-2:0], 1'b0};
            assign d_cur = den_reg[k-1];
            assign q_cur = quo_reg[k-1];
        end

        assign q_bit  = (r_cur >= {1'b0, d_cur});
        assign r_next = q_bit ? (r_cur - {1'b0, d_cur}) : r_cur;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= r_next;
                den_reg[k] <= d_cur;
                quo_reg[k] <= {q_cur[mtc_pkg::QUO_W-2:0], q_bit};
            end
        end
    end

    for (genvar j = 0; j < mtc_pkg::ROOT_STEPS; j++) begin : g_root
        localparam logic [mtc_pkg::ROOT_W-1:0] BIT =
            mtc_pkg::ROOT_W'(64'd1 << (2 * (mtc_pkg::ROOT_STEPS - 1 - j)));
        logic [mtc_pkg::ROOT_W-1:0] x_cur;
        logic [mtc_pkg::ROOT_W-1:0] r_cur;
        logic [mtc_pkg::ROOT_W-1:0] trial;
        logic                       ge;

        if (j == 0) begin : g_first
            assign x_cur = {1'b0, quo_reg[mtc_pkg::DIV_STEPS-1]};
            assign r_cur = '0;
        end else begin : g_rest
            assign x_cur = rad_reg[j-1];
            assign r_cur = acc_reg[j-1];
        end

        assign trial = r_cur + BIT;
        assign ge    = (x_cur >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j] <= ge ? (x_cur - trial) : x_cur;
                acc_reg[j] <= ge ? ((r_cur >> 1) + BIT) : (r_cur >> 1);
            end
        end
    end

    assign root = (acc_reg[mtc_pkg::ROOT_STEPS-1] > mtc_pkg::ROOT_W'(mtc_pkg::Q15_MAX))
                  ? mtc_pkg::Q15_MAX
                  : acc_reg[mtc_pkg::ROOT_STEPS-1][mtc_pkg::Q15_W-1:0];

endmodule

// File: design/magnetometer_tilt_compensation_unit.sv
// Throughput: one sample per cycle; the divide and square-root pipelines
// (47 stages, one bit per stage) set the depth, a single stage enable stalls all.
// Reset (aresetn low, synchronous): all valid bits cleared, gravity axis set to z.
// Top level of the tilt compensation unit; uses mtc_pkg, mtc_ratio and the defines header.
`include "magnetometer_tilt_compensation_unit_defines.svh"

module magnetometer_tilt_compensation_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, zero pad
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // comp_x, comp_y, comp_z, zero pad
    output logic [mtc_pkg::OUT_TW-1:0]  m_tdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SQ_W   = 2 * SW - 1;
    localparam int SUM_W  = 2 * SW;
    localparam int EXT_W  = (SUM_W > mtc_pkg::RATIO_W) ? SUM_W : mtc_pkg::RATIO_W;
    localparam int SH_W   = $clog2(EXT_W);
    localparam int PW     = SW + mtc_pkg::TRIG_W;
    localparam int KW     = 2 * mtc_pkg::TRIG_W;
    localparam int RW     = SW + 19;
    localparam int TOTAL  = 4 + mtc_pkg::RATIO_LAT + 5;
    localparam int N_RAT  = 4;

    localparam logic signed [RW-1:0] SAT_HI = RW'(mtc_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] SAT_LO = RW'(mtc_pkg::OUT_MIN);
    localparam logic signed [RW-1:0] RND_RW = RW'(mtc_pkg::ROUND_HALF);
    localparam logic signed [KW:0]   RND_K  = (KW+1)'(mtc_pkg::ROUND_HALF);
    localparam logic signed [mtc_pkg::TRIG_W-1:0] TRIG_ONE =
        signed'({1'b0, mtc_pkg::Q15_MAX});

    typedef struct packed {
        mtc_pkg::axis_t        axis;
        logic                  neg_x;
        logic                  neg_y;
        logic                  zero;
        logic signed [SW-1:0]  mx;
        logic signed [SW-1:0]  my;
        logic signed [SW-1:0]  mz;
    } side_t;

    logic                 stage_en;
    logic [TOTAL-1:0]     valid_reg;
    mtc_pkg::axis_t       axis_reg;

    // stage 1: permuted samples
    logic signed [SW-1:0] a_in [3];
    logic signed [SW-1:0] m_in [3];
    logic signed [SW-1:0] ax_next, ay_next, az_next;
    side_t                side1_next;
    logic signed [SW-1:0] ax1_reg, ay1_reg, az1_reg;
    side_t                side1_reg;

    // stage 2: squares
    logic signed [2*SW-1:0] sqx_full, sqy_full, sqz_full;
    logic [SQ_W-1:0]      sqx2_reg, sqy2_reg, sqz2_reg;
    side_t                side2_reg;

    // stage 3: norm and numerators
    logic [SUM_W-1:0]     sum3_next;
    logic [SUM_W-1:0]     sum3_reg;
    logic [SUM_W-1:0]     num3_reg [N_RAT];
    side_t                side3_next;
    side_t                side3_reg;

    // stage 4: normalised to divider width
    logic [EXT_W-1:0]     s_ext;
    logic [EXT_W-1:0]     den_sh;
    logic [EXT_W-1:0]     num_sh [N_RAT];
    logic [SH_W-1:0]      sh;
    logic [mtc_pkg::RATIO_W-1:0] num4_next [N_RAT];
    logic [mtc_pkg::RATIO_W-1:0] num4_reg  [N_RAT];
    logic [mtc_pkg::RATIO_W-1:0] den4_reg;
    side_t                side4_reg;

    logic [mtc_pkg::Q15_W-1:0] root [N_RAT];
    side_t                side_line_reg [mtc_pkg::RATIO_LAT];
    side_t                side_al;

    // stage 5: signed sines and cosines
    logic signed [mtc_pkg::TRIG_W-1:0] rt [N_RAT];
    logic signed [mtc_pkg::TRIG_W-1:0] sr5_reg, sp5_reg, cr5_reg, cp5_reg;
    side_t                side5_reg;

    // stage 6: first products
    logic signed [PW-1:0] p1_6_reg, p2_6_reg, p5_6_reg;
    logic signed [KW-1:0] p3_6_reg, p4_6_reg;
    side_t                side6_reg;

    // stage 7: rounded terms
    logic signed [RW-1:0] xsum7;
    logic signed [KW:0]   k1sum7, k2sum7;
    logic signed [RW-1:0] xh7_reg;
    logic signed [mtc_pkg::TRIG_W-1:0] k1_7_reg, k2_7_reg;
    logic signed [PW-1:0] p5_7_reg;
    side_t                side7_reg;

    // stage 8: second products
    logic signed [PW-1:0] p6_8_reg, p7_8_reg, p5_8_reg;
    logic signed [RW-1:0] xh8_reg;
    side_t                side8_reg;

    // stage 9: output
    logic signed [RW-1:0] ysum9;
    logic signed [RW-1:0] yh9;
    logic [mtc_pkg::OUT_W-1:0] sx9, sy9, sz9;
    logic [mtc_pkg::OUT_W-1:0] comp_x_next, comp_y_next, comp_z_next;
    logic [mtc_pkg::OUT_W-1:0] comp_x_reg, comp_y_reg, comp_z_reg;

    function automatic logic [mtc_pkg::OUT_W-1:0] sat_out(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] c;
        c = v;
        if (v > SAT_HI) c = SAT_HI;
        if (v < SAT_LO) c = SAT_LO;
        return c[mtc_pkg::OUT_W-1:0];
    endfunction

    assign stage_en = !valid_reg[TOTAL-1] || m_tready;
    assign s_tready = stage_en;
    assign m_tvalid = valid_reg[TOTAL-1];
    assign m_tdata  = {{(mtc_pkg::OUT_TW - 3*mtc_pkg::OUT_W){1'b0}},
                       comp_z_reg, comp_y_reg, comp_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            axis_reg  <= mtc_pkg::AXIS_Z;
        end else begin
            if (stage_en) begin
                valid_reg <= {valid_reg[TOTAL-2:0], s_tvalid};
            end
            if (cfg_we) begin
                axis_reg <= cfg_wdata;
            end
        end
    end

    // stage 1
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_in[i] = s_tdata[i*SW +: SW];
            m_in[i] = s_tdata[(3+i)*SW +: SW];
        end
        unique case (axis_reg)
            mtc_pkg::AXIS_X: begin
                ax_next = a_in[1]; ay_next = a_in[2]; az_next = a_in[0];
                side1_next.mx = m_in[1]; side1_next.my = m_in[2]; side1_next.mz = m_in[0];
            end
            mtc_pkg::AXIS_Y: begin
                ax_next = a_in[2]; ay_next = a_in[0]; az_next = a_in[1];
                side1_next.mx = m_in[2]; side1_next.my = m_in[0]; side1_next.mz = m_in[1];
            end
            default: begin
                ax_next = a_in[0]; ay_next = a_in[1]; az_next = a_in[2];
                side1_next.mx = m_in[0]; side1_next.my = m_in[1]; side1_next.mz = m_in[2];
            end
        endcase
        side1_next.axis  = axis_reg;
        side1_next.neg_x = ax_next[SW-1];
        side1_next.neg_y = ay_next[SW-1];
        side1_next.zero  = 1'b0;
    end

    assign sqx_full = ax1_reg * ax1_reg;
    assign sqy_full = ay1_reg * ay1_reg;
    assign sqz_full = az1_reg * az1_reg;

    assign sum3_next = SUM_W'(sqx2_reg) + SUM_W'(sqy2_reg) + SUM_W'(sqz2_reg);

    always_comb begin
        side3_next      = side2_reg;
        side3_next.zero = (sum3_next == '0);
    end

    // stage 4: shift right until the norm fits the divider
    always_comb begin
        s_ext = EXT_W'(sum3_reg);
        sh    = '0;
        for (int i = mtc_pkg::RATIO_W; i < EXT_W; i++) begin
            if (s_ext[i]) sh = SH_W'(i - mtc_pkg::RATIO_W + 1);
        end
        den_sh = s_ext >> sh;
        for (int k = 0; k < N_RAT; k++) begin
            num_sh[k]    = EXT_W'(num3_reg[k]) >> sh;
            num4_next[k] = (num_sh[k] > den_sh) ? den_sh[mtc_pkg::RATIO_W-1:0]
                                                : num_sh[k][mtc_pkg::RATIO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            ax1_reg   <= ax_next;
            ay1_reg   <= ay_next;
            az1_reg   <= az_next;
            side1_reg <= side1_next;

            sqx2_reg  <= sqx_full[SQ_W-1:0];
            sqy2_reg  <= sqy_full[SQ_W-1:0];
            sqz2_reg  <= sqz_full[SQ_W-1:0];
            side2_reg <= side1_reg;

            sum3_reg    <= sum3_next;
            num3_reg[0] <= SUM_W'(sqy2_reg);
            num3_reg[1] <= SUM_W'(sqx2_reg);
            num3_reg[2] <= SUM_W'(sqx2_reg) + SUM_W'(sqz2_reg);
            num3_reg[3] <= SUM_W'(sqy2_reg) + SUM_W'(sqz2_reg);
            side3_reg   <= side3_next;

            den4_reg  <= den_sh[mtc_pkg::RATIO_W-1:0];
            num4_reg  <= num4_next;
            side4_reg <= side3_reg;

            side_line_reg[0] <= side4_reg;
            for (int i = 1; i < mtc_pkg::RATIO_LAT; i++) begin
                side_line_reg[i] <= side_line_reg[i-1];
            end
        end
    end

    // sin roll, sin pitch, cos roll, cos pitch
    for (genvar k = 0; k < N_RAT; k++) begin : g_ratio
        mtc_ratio u_ratio (
            .aclk (aclk),
            .en   (stage_en),
            .num  (num4_reg[k]),
            .den  (den4_reg),
            .root (root[k])
        );
        assign rt[k] = signed'({1'b0, root[k]});
    end

    assign side_al = side_line_reg[mtc_pkg::RATIO_LAT-1];

    assign xsum7  = RW'(p1_6_reg) + RW'(p2_6_reg) + RND_RW;
    assign k1sum7 = (KW+1)'(p3_6_reg) + RND_K;
    assign k2sum7 = (KW+1)'(p4_6_reg) + RND_K;

    assign ysum9 = RW'(p5_8_reg) + RW'(p6_8_reg) - RW'(p7_8_reg) + RND_RW;
    assign yh9   = ysum9 >>> mtc_pkg::FRAC_BITS;
    assign sx9   = sat_out(xh8_reg);
    assign sy9   = sat_out(yh9);
    assign sz9   = sat_out(RW'(side8_reg.mz));

    always_comb begin
        unique case (side8_reg.axis)
            mtc_pkg::AXIS_X: begin
                comp_x_next = sz9; comp_y_next = sx9; comp_z_next = sy9;
            end
            mtc_pkg::AXIS_Y: begin
                comp_x_next = sy9; comp_y_next = sz9; comp_z_next = sx9;
            end
            mtc_pkg::AXIS_Z: begin
                comp_x_next = sx9; comp_y_next = sy9; comp_z_next = sz9;
            end
            default: begin
                comp_x_next = sat_out(RW'(side8_reg.mx));
                comp_y_next = sat_out(RW'(side8_reg.my));
                comp_z_next = sz9;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en) begin
            if (side_al.zero) begin
                sr5_reg <= '0;
                sp5_reg <= '0;
                cr5_reg <= TRIG_ONE;
                cp5_reg <= TRIG_ONE;
            end else begin
                sr5_reg <= side_al.neg_y ? -rt[0] : rt[0];
                sp5_reg <= side_al.neg_x ? -rt[1] : rt[1];
                cr5_reg <= rt[2];
                cp5_reg <= rt[3];
            end
            side5_reg <= side_al;

            p1_6_reg  <= side5_reg.mx * cp5_reg;
            p2_6_reg  <= side5_reg.mz * sp5_reg;
            p5_6_reg  <= side5_reg.my * cr5_reg;
            p3_6_reg  <= sr5_reg * sp5_reg;
            p4_6_reg  <= sr5_reg * cp5_reg;
            side6_reg <= side5_reg;

            xh7_reg   <= xsum7 >>> mtc_pkg::FRAC_BITS;
            k1_7_reg  <= mtc_pkg::TRIG_W'(k1sum7 >>> mtc_pkg::FRAC_BITS);
            k2_7_reg  <= mtc_pkg::TRIG_W'(k2sum7 >>> mtc_pkg::FRAC_BITS);
            p5_7_reg  <= p5_6_reg;
            side7_reg <= side6_reg;

            p6_8_reg  <= side7_reg.mx * k1_7_reg;
            p7_8_reg  <= side7_reg.mz * k2_7_reg;
            p5_8_reg  <= p5_7_reg;
            xh8_reg   <= xh7_reg;
            side8_reg <= side7_reg;

            comp_x_reg <= comp_x_next;
            comp_y_reg <= comp_y_next;
            comp_z_reg <= comp_z_next;
        end
    end

    `MTC_ASSERT_NEXT(a_stall_freezes_pipe, !stage_en, $stable(valid_reg), "valid bits moved during stall")
    `MTC_ASSERT_NEXT(a_transfer_enters, s_tvalid && s_tready, valid_reg[0], "accepted transfer not tracked")
    `MTC_ASSERT_SAME(a_result_from_pipe, $rose(m_tvalid), $past(valid_reg[TOTAL-2]), "result without item")

endmodule
